// ----- hw/rtl/rotated_scaled_text_overlay_defines.svh -----
// assertion macros shared by the overlay rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ROTATED_SCALED_TEXT_OVERLAY_DEFINES_SVH
`define ROTATED_SCALED_TEXT_OVERLAY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSTO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rsto check failed");

// next-cycle implication, disabled during reset
`define RSTO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rsto check failed");

`endif

// ----- hw/rtl/rsto_pkg.sv -----
// constants, geometry and codes for the rotated scaled text overlay
// no dependencies; used by the interfaces, the ram wrapper users and the top level
`default_nettype none

package rsto_pkg;

  // field widths
  localparam int TYPE_W    = 2;
  localparam int INDEX_W   = 12;
  localparam int DATA_W    = 8;
  localparam int PANEL_X_W = 10;
  localparam int PANEL_Y_W = 11;
  localparam int SRC_X_W   = 10;
  localparam int SRC_Y_W   = 9;
  localparam int COLOR_W   = 16;
  localparam int ROW_W     = 5;
  localparam int LLEN_W    = 7;

  // geometry
  localparam int PANEL_WIDTH     = 720;
  localparam int PANEL_HEIGHT    = 1280;
  localparam int SOURCE_WIDTH    = 640;
  localparam int SOURCE_HEIGHT   = 400;
  localparam int FIT_NUMERATOR   = 9;
  localparam int FIT_DENOMINATOR = 5;

  localparam int GLYPH_W    = 8;
  localparam int GLYPH_H    = 16;
  localparam int GLYPH_SH   = $clog2(GLYPH_H);
  localparam int BIT_W      = $clog2(GLYPH_W);
  localparam int LINE_DEPTH = 80;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int FONT_DEPTH = 4096;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int TEXT_ROWS  = SOURCE_HEIGHT / GLYPH_H;
  localparam int LINE_CAP   = (LINE_DEPTH < SOURCE_WIDTH / GLYPH_W) ?
                              LINE_DEPTH : SOURCE_WIDTH / GLYPH_W;

  localparam logic [DATA_W-1:0] SPACE_CODE = 8'h20;

  // axis placement, y axis runs along panel x, x axis along panel y
  localparam int LEN_Y_FIT = SOURCE_HEIGHT * FIT_NUMERATOR / FIT_DENOMINATOR;
  localparam int OFF_Y_FIT = (PANEL_WIDTH - LEN_Y_FIT) / 2;
  localparam int OFF_Y_DOT = (PANEL_WIDTH - SOURCE_HEIGHT) / 2;
  localparam int LEN_X_FIT = SOURCE_WIDTH * FIT_NUMERATOR / FIT_DENOMINATOR;
  localparam int OFF_X_FIT = (PANEL_HEIGHT - LEN_X_FIT) / 2;
  localparam int OFF_X_DOT = (PANEL_HEIGHT - SOURCE_WIDTH) / 2;

  localparam int LEN_MAX_A = (LEN_Y_FIT > SOURCE_HEIGHT) ? LEN_Y_FIT : SOURCE_HEIGHT;
  localparam int LEN_MAX_B = (LEN_X_FIT > SOURCE_WIDTH) ? LEN_X_FIT : SOURCE_WIDTH;
  localparam int LEN_MAX   = (LEN_MAX_A > LEN_MAX_B) ? LEN_MAX_A : LEN_MAX_B;
  localparam int IDX_W     = $clog2(LEN_MAX);
  localparam int P_W       = $clog2(LEN_MAX * FIT_DENOMINATOR + 1);
  localparam int D_W       = $clog2((PANEL_HEIGHT > LEN_MAX ? PANEL_HEIGHT : LEN_MAX) +
                                    (1 << PANEL_Y_W)) + 2;

  // reciprocal of the numerator, underestimates the quotient by at most one
  localparam int RCP_K     = P_W;
  localparam int RCP_W     = RCP_K + 1;
  localparam int RECIP_FIT = (1 << RCP_K) / FIT_NUMERATOR;
  localparam int RECIP_DOT = 1 << RCP_K;

  // register file
  localparam int NUM_REGS = 5;
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int PDATA_W  = 32;
  localparam int REG_IX_W = PADDR_W - 2;

  localparam logic MODE_DOT = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PIXEL = 2'd0,
    REQ_FONT  = 2'd1,
    REQ_CHAR  = 2'd2
  } req_type_e;

  typedef enum logic [REG_IX_W-1:0] {
    REG_SCALE_MODE  = 3'd0,
    REG_TEXT_ROW    = 3'd1,
    REG_LINE_LENGTH = 3'd2,
    REG_FG_COLOR    = 3'd3,
    REG_BG_COLOR    = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// ----- hw/rtl/rsto_if.sv -----
// request and response channels of the overlay, valid/ready with payload
// depends on rsto_pkg for field widths
`default_nettype none

interface rsto_req_if;
  import rsto_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    req_type;
  logic [INDEX_W-1:0]   load_index;
  logic [DATA_W-1:0]    load_data;
  logic [PANEL_X_W-1:0] panel_x;
  logic [PANEL_Y_W-1:0] panel_y;

  modport source (output valid, req_type, load_index, load_data, panel_x, panel_y,
                  input ready);
  modport sink   (input valid, req_type, load_index, load_data, panel_x, panel_y,
                  output ready);
endinterface

interface rsto_rsp_if;
  import rsto_pkg::*;

  logic               valid;
  logic               ready;
  logic               in_image;
  logic [SRC_X_W-1:0] src_x;
  logic [SRC_Y_W-1:0] src_y;
  logic               write_pixel;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, in_image, src_x, src_y, write_pixel, pixel_color,
                  input ready);
  modport sink   (input valid, in_image, src_x, src_y, write_pixel, pixel_color,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rsto_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rsto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rotated_scaled_text_overlay.sv -----
// top level of the rotated scaled text overlay: six-stage pixel pipeline,
// register file, line buffer and font store
// depends on rsto_pkg, rsto_if, rsto_ram and the assertion macro header
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+----------------------------------------------
//  req     | in  | valid/ready       | req_type, load_index, load_data, panel_x/y
//  rsp     | out | valid/ready       | in_image, src_x, src_y, write_pixel, color
//  apb     | in  | psel/penable/rdy  | paddr, pwdata, prdata (five registers)
//
//  one word per cycle sustained while rsp takes pixel words; a pixel word passes six
//  pipeline registers before it is offered on rsp: request, axis offset and scale,
//  reciprocal multiply, quotient fix and clamp, mirror and line buffer read, font read
//  load words travel the same pipe and write the stores in order with pixel reads
//  reset clears valid bits and registers only; both stores start unwritten, no clear pass
//  a stalled rsp holds stage six; earlier stages keep filling bubbles behind it
`default_nettype none
`include "rotated_scaled_text_overlay_defines.svh"

module rotated_scaled_text_overlay (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rsto_req_if.sink                          req,
  rsto_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rsto_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rsto_pkg::PDATA_W-1:0] pwdata,
  output logic      [rsto_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import rsto_pkg::*;

  // ---------------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------------
  logic               scale_mode_q;
  logic [ROW_W-1:0]   text_row_q;
  logic [LLEN_W-1:0]  line_length_q;
  logic [COLOR_W-1:0] fg_color_q;
  logic [COLOR_W-1:0] bg_color_q;
  logic               cfg_wr;
  reg_idx_e           reg_ix;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_ix = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q  <= 1'b0;
      text_row_q    <= '0;
      line_length_q <= '0;
      fg_color_q    <= '1;
      bg_color_q    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_ix)
        REG_SCALE_MODE:  scale_mode_q  <= pwdata[0];
        REG_TEXT_ROW:    text_row_q    <= pwdata[ROW_W-1:0];
        REG_LINE_LENGTH: line_length_q <= pwdata[LLEN_W-1:0];
        REG_FG_COLOR:    fg_color_q    <= pwdata[COLOR_W-1:0];
        REG_BG_COLOR:    bg_color_q    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_ix)
      REG_SCALE_MODE:  prdata = PDATA_W'(scale_mode_q);
      REG_TEXT_ROW:    prdata = PDATA_W'(text_row_q);
      REG_LINE_LENGTH: prdata = PDATA_W'(line_length_q);
      REG_FG_COLOR:    prdata = PDATA_W'(fg_color_q);
      REG_BG_COLOR:    prdata = PDATA_W'(bg_color_q);
      default:         prdata = '0;
    endcase
  end

  logic dot;
  assign dot = (scale_mode_q == MODE_DOT);

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its successor loads
  // words that are not pixels leave the last stage without waiting on rsp
  // ---------------------------------------------------------------------------
  logic [5:0] vld_q;
  logic [5:0] en;
  logic       pix6_q;
  logic       req_known;

  assign en[5] = !vld_q[5] || !pix6_q || rsp.ready;
  assign en[4] = !vld_q[4] || en[5];
  assign en[3] = !vld_q[3] || en[4];
  assign en[2] = !vld_q[2] || en[3];
  assign en[1] = !vld_q[1] || en[2];
  assign en[0] = !vld_q[0] || en[1];
  assign req.ready = en[0];

  // unknown request codes are dropped at the door
  assign req_known = (req.req_type == REQ_PIXEL) || (req.req_type == REQ_FONT) ||
                     (req.req_type == REQ_CHAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= req.valid && req_known;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
      if (en[5]) vld_q[5] <= vld_q[4];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: captured request word
  // ---------------------------------------------------------------------------
  req_type_e            type1_q;
  logic [INDEX_W-1:0]   idx1_q;
  logic [DATA_W-1:0]    data1_q;
  logic [PANEL_X_W-1:0] px1_q;
  logic [PANEL_Y_W-1:0] py1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      type1_q <= req_type_e'(req.req_type);
      idx1_q  <= req.load_index;
      data1_q <= req.load_data;
      px1_q   <= req.panel_x;
      py1_q   <= req.panel_y;
    end
  end

  // offset into the placed image on each axis, letterbox test, scale by denominator in fit mode
  logic signed [D_W-1:0] ix, iy;
  logic        [D_W-1:0] len_x, len_y;
  logic                  ok_x, ok_y;
  logic        [P_W-1:0] p_x, p_y;

  assign len_x = dot ? D_W'(SOURCE_WIDTH)  : D_W'(LEN_X_FIT);
  assign len_y = dot ? D_W'(SOURCE_HEIGHT) : D_W'(LEN_Y_FIT);
  assign ix = $signed(D_W'(py1_q)) - $signed(dot ? D_W'(OFF_X_DOT) : D_W'(OFF_X_FIT));
  assign iy = $signed(D_W'(px1_q)) - $signed(dot ? D_W'(OFF_Y_DOT) : D_W'(OFF_Y_FIT));

  assign ok_x = (D_W'(py1_q) < D_W'(PANEL_HEIGHT)) && !ix[D_W-1] && (D_W'(ix) < len_x);
  assign ok_y = (D_W'(px1_q) < D_W'(PANEL_WIDTH))  && !iy[D_W-1] && (D_W'(iy) < len_y);

  assign p_x = dot ? P_W'(ix[IDX_W-1:0])
                   : P_W'(ix[IDX_W-1:0]) * P_W'(FIT_DENOMINATOR);
  assign p_y = dot ? P_W'(iy[IDX_W-1:0])
                   : P_W'(iy[IDX_W-1:0]) * P_W'(FIT_DENOMINATOR);

  // ---------------------------------------------------------------------------
  // stage 2: scaled offsets
  // ---------------------------------------------------------------------------
  req_type_e          type2_q;
  logic [INDEX_W-1:0] idx2_q;
  logic [DATA_W-1:0]  data2_q;
  logic               ok2_q;
  logic [P_W-1:0]     p_x2_q, p_y2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      type2_q <= type1_q;
      idx2_q  <= idx1_q;
      data2_q <= data1_q;
      ok2_q   <= ok_x && ok_y;
      p_x2_q  <= p_x;
      p_y2_q  <= p_y;
    end
  end

  // quotient estimate by reciprocal multiply, at most one short
  logic [RCP_W-1:0]     recip;
  logic [P_W+RCP_W-1:0] prod_x, prod_y;

  assign recip  = dot ? RCP_W'(RECIP_DOT) : RCP_W'(RECIP_FIT);
  assign prod_x = (P_W+RCP_W)'(p_x2_q) * (P_W+RCP_W)'(recip);
  assign prod_y = (P_W+RCP_W)'(p_y2_q) * (P_W+RCP_W)'(recip);

  // ---------------------------------------------------------------------------
  // stage 3: quotient estimates
  // ---------------------------------------------------------------------------
  req_type_e          type3_q;
  logic [INDEX_W-1:0] idx3_q;
  logic [DATA_W-1:0]  data3_q;
  logic               ok3_q;
  logic [P_W-1:0]     p_x3_q, p_y3_q;
  logic [P_W-1:0]     qe_x3_q, qe_y3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      type3_q <= type2_q;
      idx3_q  <= idx2_q;
      data3_q <= data2_q;
      ok3_q   <= ok2_q;
      p_x3_q  <= p_x2_q;
      p_y3_q  <= p_y2_q;
      qe_x3_q <= P_W'(prod_x >> RCP_K);
      qe_y3_q <= P_W'(prod_y >> RCP_K);
    end
  end

  // fix the quotient, then clamp to the last source column or line
  logic [P_W-1:0]     num;
  logic [P_W-1:0]     rem_x, rem_y;
  logic [P_W-1:0]     q_x, q_y;
  logic [SRC_X_W-1:0] sx;
  logic [SRC_Y_W-1:0] sy;

  assign num   = dot ? P_W'(1) : P_W'(FIT_NUMERATOR);
  assign rem_x = p_x3_q - P_W'(qe_x3_q * num);
  assign rem_y = p_y3_q - P_W'(qe_y3_q * num);
  assign q_x   = (rem_x >= num) ? qe_x3_q + P_W'(1) : qe_x3_q;
  assign q_y   = (rem_y >= num) ? qe_y3_q + P_W'(1) : qe_y3_q;
  assign sx    = (q_x >= P_W'(SOURCE_WIDTH))  ? SRC_X_W'(SOURCE_WIDTH - 1)  : SRC_X_W'(q_x);
  assign sy    = (q_y >= P_W'(SOURCE_HEIGHT)) ? SRC_Y_W'(SOURCE_HEIGHT - 1) : SRC_Y_W'(q_y);

  // ---------------------------------------------------------------------------
  // stage 4: source coordinate
  // ---------------------------------------------------------------------------
  req_type_e          type4_q;
  logic [INDEX_W-1:0] idx4_q;
  logic [DATA_W-1:0]  data4_q;
  logic               ok4_q;
  logic [SRC_X_W-1:0] sx4_q;
  logic [SRC_Y_W-1:0] sy4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      type4_q <= type3_q;
      idx4_q  <= idx3_q;
      data4_q <= data3_q;
      ok4_q   <= ok3_q;
      sx4_q   <= sx;
      sy4_q   <= sy;
    end
  end

  // mirror x, text band test and character column
  logic [SRC_X_W-1:0] sxm;
  logic               band;
  logic [COL_W-1:0]   col;
  logic [LLEN_W-1:0]  len_eff;
  logic               lb_we;
  logic [DATA_W-1:0]  lb_rdata;

  assign sxm     = SRC_X_W'(SOURCE_WIDTH - 1) - sx4_q;
  assign band    = (text_row_q < TEXT_ROWS) &&
                   (SRC_Y_W'(text_row_q) == (sy4_q >> GLYPH_SH));
  assign col     = COL_W'(sxm >> BIT_W);
  assign len_eff = (line_length_q > LLEN_W'(LINE_CAP)) ? LLEN_W'(LINE_CAP) : line_length_q;

  // character loads past the buffer end are ignored
  assign lb_we = en[4] && vld_q[3] && (type4_q == REQ_CHAR) && (idx4_q < LINE_DEPTH);

  rsto_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (idx4_q[COL_W-1:0]),
    .wdata_i (data4_q),
    .re_i    (en[4]),
    .raddr_i (col),
    .rdata_o (lb_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 5: mirrored coordinate, band flag, line buffer data
  // ---------------------------------------------------------------------------
  req_type_e            type5_q;
  logic [INDEX_W-1:0]   idx5_q;
  logic [DATA_W-1:0]    data5_q;
  logic                 ok5_q;
  logic [SRC_X_W-1:0]   sxm5_q;
  logic [SRC_Y_W-1:0]   sy5_q;
  logic                 wp5_q;
  logic                 colok5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      type5_q  <= type4_q;
      idx5_q   <= idx4_q;
      data5_q  <= data4_q;
      ok5_q    <= ok4_q;
      sxm5_q   <= sxm;
      sy5_q    <= sy4_q;
      wp5_q    <= ok4_q && band;
      colok5_q <= (LLEN_W'(col) < len_eff);
    end
  end

  // columns past the line render as spaces
  logic [DATA_W-1:0]  code;
  logic [FONT_AW-1:0] font_raddr;
  logic               font_we;
  logic [DATA_W-1:0]  font_rdata;

  assign code       = colok5_q ? lb_rdata : SPACE_CODE;
  assign font_raddr = FONT_AW'({code, sy5_q[GLYPH_SH-1:0]});
  assign font_we    = en[5] && vld_q[4] && (type5_q == REQ_FONT);

  rsto_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (idx5_q[FONT_AW-1:0]),
    .wdata_i (data5_q),
    .re_i    (en[5]),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 6: output word, glyph byte from the font store
  // ---------------------------------------------------------------------------
  logic               ok6_q;
  logic [SRC_X_W-1:0] sxm6_q;
  logic [SRC_Y_W-1:0] sy6_q;
  logic               wp6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix6_q <= 1'b0;
    end else if (en[5]) begin
      pix6_q <= (type5_q == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ok6_q  <= ok5_q;
      sxm6_q <= sxm5_q;
      sy6_q  <= sy5_q;
      wp6_q  <= wp5_q;
    end
  end

  // glyph msb is the leftmost dot
  logic [BIT_W-1:0] bit_sel;
  logic             glyph_bit;

  assign bit_sel   = ~sxm6_q[BIT_W-1:0];
  assign glyph_bit = font_rdata[bit_sel];

  assign rsp.valid       = vld_q[5] && pix6_q;
  assign rsp.in_image    = ok6_q;
  assign rsp.src_x       = ok6_q ? sxm6_q : '0;
  assign rsp.src_y       = ok6_q ? sy6_q : '0;
  assign rsp.write_pixel = wp6_q;
  assign rsp.pixel_color = !wp6_q ? '0 : (glyph_bit ? fg_color_q : bg_color_q);

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `RSTO_ASSERT_IMP(a_ready_only_when_full, clk_i, rst_ni, !req.ready, &vld_q)
  `RSTO_ASSERT_NXT(a_stalled_word_kept, clk_i, rst_ni, rsp.valid && !rsp.ready,
                   rsp.valid && $stable(sxm6_q) && $stable(sy6_q))
  `RSTO_ASSERT_IMP(a_text_in_band, clk_i, rst_ni, rsp.valid && rsp.write_pixel,
                   rsp.in_image && (SRC_Y_W'(text_row_q) == (rsp.src_y >> GLYPH_SH)))
  `RSTO_ASSERT_IMP(a_coord_in_source, clk_i, rst_ni, rsp.valid,
                   (rsp.src_x < SOURCE_WIDTH) && (rsp.src_y < SOURCE_HEIGHT))

endmodule

`default_nettype wire

// ----- bench/tb_rotated_scaled_text_overlay.sv -----
// testbench for the rotated scaled text overlay: directed and random words on the request
// channel, every pixel result checked against an in-bench model of mapping and glyph lookup
// depends on rsto_pkg, the rsto_if channel interfaces and the overlay top level
module tb_rotated_scaled_text_overlay;
  import rsto_pkg::*;

  // request code the block has no use for, must be dropped silently
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  // pipeline is six deep, a little margin before touching registers
  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_PHASES    = 8;
  // store fill loads ride on top of these, so keep the phases short
  localparam int PHASE_WORDS   = 55;

  typedef struct packed {
    logic [TYPE_W-1:0]    kind;
    logic [INDEX_W-1:0]   index;
    logic [DATA_W-1:0]    data;
    logic [PANEL_X_W-1:0] px;
    logic [PANEL_Y_W-1:0] py;
  } req_word_t;

  typedef struct packed {
    logic               in_image;
    logic [SRC_X_W-1:0] src_x;
    logic [SRC_Y_W-1:0] src_y;
    logic               write_pixel;
    logic [COLOR_W-1:0] pixel_color;
  } pix_word_t;

  // keeps a copy of the registers and both stores, predicts each pixel word
  class overlay_scoreboard;
    pix_word_t         pending_pixels[$];
    logic [DATA_W-1:0] glyph_rom[FONT_DEPTH];
    bit                glyph_set[FONT_DEPTH];
    logic [DATA_W-1:0] row_chars[LINE_DEPTH];
    bit                char_set[LINE_DEPTH];
    bit                scale_dot;
    logic [ROW_W-1:0]  row_sel;
    logic [LLEN_W-1:0] row_len;
    logic [COLOR_W-1:0] fg, bg;
    int                errors;
    int                checked;

    function new();
      scale_dot = 1'b0;
      row_sel   = '0;
      row_len   = '0;
      fg        = 16'hFFFF;
      bg        = 16'h0000;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(reg_idx_e ix, logic [PDATA_W-1:0] v);
      case (ix)
        REG_SCALE_MODE:  scale_dot = (v[0] == MODE_DOT);
        REG_TEXT_ROW:    row_sel = v[ROW_W-1:0];
        REG_LINE_LENGTH: row_len = v[LLEN_W-1:0];
        REG_FG_COLOR:    fg = v[COLOR_W-1:0];
        REG_BG_COLOR:    bg = v[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // one panel axis onto one source axis, 0 in the letterbox
    function bit map_axis(int pos, int panel, int src, int num, int den, output int s);
      int len, off, i;
      len = src * num / den;
      off = (panel - len) / 2;
      i   = pos - off;
      s   = 0;
      if (pos >= panel || i < 0 || i >= len) return 1'b0;
      s = i * den / num;
      if (s >= src) s = src - 1;
      return 1'b1;
    endfunction

    // 0 letterbox, 1 inside the image, 2 inside the text band; col is -1 past the line
    function int locate(int px, int py, output int sy, output int sxm,
                        output int col, output int line);
      int num, den, sx, y0, lim;
      num  = scale_dot ? 1 : FIT_NUMERATOR;
      den  = scale_dot ? 1 : FIT_DENOMINATOR;
      sxm  = 0;
      col  = -1;
      line = 0;
      if (!map_axis(px, PANEL_WIDTH, SOURCE_HEIGHT, num, den, sy)) return 0;
      if (!map_axis(py, PANEL_HEIGHT, SOURCE_WIDTH, num, den, sx)) begin
        sy = 0;
        return 0;
      end
      sxm = SOURCE_WIDTH - 1 - sx;
      if (int'(row_sel) >= TEXT_ROWS) return 1;
      y0 = int'(row_sel) * GLYPH_H;
      if (sy < y0 || sy >= y0 + GLYPH_H) return 1;
      line = sy - y0;
      lim  = (int'(row_len) < LINE_CAP) ? int'(row_len) : LINE_CAP;
      col  = sxm / GLYPH_W;
      if (col >= lim) col = -1;
      return 2;
    endfunction

    function int glyph_addr(int col, int line);
      logic [DATA_W-1:0] code;
      code = (col < 0) ? SPACE_CODE : row_chars[col];
      return (int'(code) * GLYPH_H + line) % FONT_DEPTH;
    endfunction

    // first store entry this pixel would read before anything was written there
    function bit find_unwritten(int px, int py, output bit is_char, output int ix);
      int sy, sxm, col, line;
      is_char = 1'b0;
      ix      = 0;
      if (locate(px, py, sy, sxm, col, line) != 2) return 1'b0;
      if (col >= 0 && !char_set[col]) begin
        is_char = 1'b1;
        ix      = col;
        return 1'b1;
      end
      ix = glyph_addr(col, line);
      return !glyph_set[ix];
    endfunction

    function void note_input(req_word_t w);
      pix_word_t e;
      int sy, sxm, col, line, k;
      logic [DATA_W-1:0] g;
      case (w.kind)
        REQ_FONT: begin
          glyph_rom[w.index] = w.data;
          glyph_set[w.index] = 1'b1;
        end
        REQ_CHAR: begin
          if (int'(w.index) < LINE_DEPTH) begin
            row_chars[w.index] = w.data;
            char_set[w.index]  = 1'b1;
          end
        end
        REQ_PIXEL: begin
          e = '0;
          k = locate(int'(w.px), int'(w.py), sy, sxm, col, line);
          if (k > 0) begin
            e.in_image = 1'b1;
            e.src_x    = SRC_X_W'(sxm);
            e.src_y    = SRC_Y_W'(sy);
          end
          if (k == 2) begin
            g = glyph_rom[glyph_addr(col, line)];
            e.write_pixel = 1'b1;
            e.pixel_color = ((g & (8'h80 >> (sxm % GLYPH_W))) != 0) ? fg : bg;
          end
          pending_pixels.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(pix_word_t got);
      pix_word_t exp;
      if (pending_pixels.size() == 0) begin
        $error("result word with no pixel pending");
        errors++;
        return;
      end
      exp = pending_pixels.pop_front();
      checked++;
      if (got.in_image !== exp.in_image) begin
        $error("in_image: expected %0d, got %0d", exp.in_image, got.in_image);
        errors++;
      end
      if (got.src_x !== exp.src_x) begin
        $error("src_x: expected %0d, got %0d", exp.src_x, got.src_x);
        errors++;
      end
      if (got.src_y !== exp.src_y) begin
        $error("src_y: expected %0d, got %0d", exp.src_y, got.src_y);
        errors++;
      end
      if (got.write_pixel !== exp.write_pixel) begin
        $error("write_pixel: expected %0d, got %0d", exp.write_pixel, got.write_pixel);
        errors++;
      end
      if (got.pixel_color !== exp.pixel_color) begin
        $error("pixel_color: expected %h, got %h", exp.pixel_color, got.pixel_color);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rsto_req_if req_ch ();
  rsto_rsp_if rsp_ch ();

  rotated_scaled_text_overlay dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  overlay_scoreboard sb;
  bit quiet;          // no idling on either side in the closing phase
  int words_sent;
  int settings_run;

  always #5 clk_i = ~clk_i;

  // result side stalls in random bursts between open stretches
  initial begin : sink_ready
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 25)) @(negedge clk_i);
      end
    end
  end

  // every accepted result word goes straight to the checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(pix_word_t'({rsp_ch.in_image, rsp_ch.src_x, rsp_ch.src_y,
                                   rsp_ch.write_pixel, rsp_ch.pixel_color}));
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb_rotated_scaled_text_overlay: done, errors");
    $finish;
  end

  // one request word, with an occasional idle burst ahead of it
  task automatic send_word(req_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= w.kind;
    req_ch.load_index <= w.index;
    req_ch.load_data  <= w.data;
    req_ch.panel_x    <= w.px;
    req_ch.panel_y    <= w.py;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_input(w);
    words_sent++;
  endtask

  // unused panel fields carry noise so they toggle too
  task automatic send_load(logic [TYPE_W-1:0] kind, int ix, int data);
    req_word_t w;
    w.kind  = kind;
    w.index = INDEX_W'(ix);
    w.data  = DATA_W'(data);
    w.px    = PANEL_X_W'($urandom);
    w.py    = PANEL_Y_W'($urandom);
    send_word(w);
  endtask

  // mostly printable codes so the glyph set stays small
  function automatic int pick_code();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(8'h20, 8'h3F);
  endfunction

  // a pixel never reads a store entry that has not been loaded, so fill gaps first
  task automatic send_pixel(int px, int py);
    req_word_t w;
    bit is_char;
    int ix;
    while (sb.find_unwritten(px, py, is_char, ix)) begin
      if (is_char) send_load(REQ_CHAR, ix, pick_code());
      else send_load(REQ_FONT, ix, $urandom_range(0, 255));
    end
    w.kind  = REQ_PIXEL;
    w.index = INDEX_W'($urandom);
    w.data  = DATA_W'($urandom);
    w.px    = PANEL_X_W'(px);
    w.py    = PANEL_Y_W'(py);
    send_word(w);
  endtask

  // panel column landing in the configured text band
  function automatic int band_panel_x();
    int num, den, off, y0;
    num = sb.scale_dot ? 1 : FIT_NUMERATOR;
    den = sb.scale_dot ? 1 : FIT_DENOMINATOR;
    if (int'(sb.row_sel) >= TEXT_ROWS) return $urandom_range(0, PANEL_WIDTH - 1);
    off = (PANEL_WIDTH - SOURCE_HEIGHT * num / den) / 2;
    y0  = int'(sb.row_sel) * GLYPH_H;
    return off + (y0 * num + den - 1) / den + $urandom_range(0, GLYPH_H * num / den - 1);
  endfunction

  // panel row inside the mapped image for the current mode
  function automatic int image_panel_y();
    int num, den, len;
    num = sb.scale_dot ? 1 : FIT_NUMERATOR;
    den = sb.scale_dot ? 1 : FIT_DENOMINATOR;
    len = SOURCE_WIDTH * num / den;
    return (PANEL_HEIGHT - len) / 2 + $urandom_range(0, len - 1);
  endfunction

  // lower valid, let every pending pixel come out, then let loads settle
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_reg(reg_idx_e ix, logic [PDATA_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ix, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(ix, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int mode_v, row_v, len_v, fg_v, bg_v;
    sb                = new();
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = '0;
    req_ch.load_index = '0;
    req_ch.load_data  = '0;
    req_ch.panel_x    = '0;
    req_ch.panel_y    = '0;
    quiet             = 1'b0;
    words_sent        = 0;
    settings_run      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // store extremes, code zero in column 0, ignored column loads and the unknown code
    send_load(REQ_FONT, 0, 8'hFF);
    send_load(REQ_FONT, FONT_DEPTH - 1, 8'h00);
    send_load(REQ_FONT, 12'h555, 8'hAA);
    send_load(REQ_CHAR, 0, 8'h00);
    send_load(REQ_CHAR, LINE_DEPTH - 1, 8'hFF);
    send_load(REQ_CHAR, LINE_DEPTH, 8'h41);
    send_load(REQ_CHAR, FONT_DEPTH - 1, 8'h42);
    send_load(REQ_UNKNOWN, FONT_DEPTH - 1, 8'hFF);
    // reset settings: zero line length, whole row renders as spaces
    send_pixel(0, 64);
    send_pixel(PANEL_WIDTH - 1, 1215);
    send_pixel(0, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          mode_v = 0; row_v = 0; len_v = LINE_DEPTH; fg_v = 16'hFFFF; bg_v = 16'h0000;
        end
        1: begin
          mode_v = 1; row_v = TEXT_ROWS - 1; len_v = 127; fg_v = 16'h0000; bg_v = 16'hFFFF;
        end
        2: begin
          // row beyond the source, nothing painted
          mode_v = 0; row_v = 31; len_v = 0;
          fg_v = $urandom_range(0, 16'hFFFF); bg_v = $urandom_range(0, 16'hFFFF);
        end
        3: begin
          mode_v = 1; row_v = TEXT_ROWS; len_v = LINE_DEPTH + 1;
          fg_v = $urandom_range(0, 16'hFFFF); bg_v = $urandom_range(0, 16'hFFFF);
        end
        default: begin
          mode_v = $urandom_range(0, 1);
          row_v  = ($urandom_range(0, 4) == 0) ? $urandom_range(TEXT_ROWS, 31)
                                               : $urandom_range(0, TEXT_ROWS - 1);
          len_v  = $urandom_range(0, 127);
          fg_v   = $urandom_range(0, 16'hFFFF);
          bg_v   = $urandom_range(0, 16'hFFFF);
        end
      endcase
      write_reg(REG_SCALE_MODE, PDATA_W'(mode_v));
      write_reg(REG_TEXT_ROW, PDATA_W'(row_v));
      write_reg(REG_LINE_LENGTH, PDATA_W'(len_v));
      write_reg(REG_FG_COLOR, PDATA_W'(fg_v));
      write_reg(REG_BG_COLOR, PDATA_W'(bg_v));
      settings_run++;
      quiet = (ph == NUM_PHASES - 1);

      if (ph == 0) begin
        // code zero in column 0, last column, image corners, letterbox and out of range
        send_pixel(0, 1204);
        send_pixel(0, 64);
        send_pixel(PANEL_WIDTH - 1, 1215);
        send_pixel(0, 63);
        send_pixel(0, 1216);
        send_pixel(1023, 2047);
        send_pixel(PANEL_WIDTH, 640);
        send_pixel(PANEL_WIDTH / 2 - 1, PANEL_HEIGHT / 2);
      end

      // mostly text band pixels with random content, the rest loads and noise
      repeat (PHASE_WORDS) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_pixel(band_panel_x(), image_panel_y());
          11, 12: send_pixel($urandom_range(0, 1023), $urandom_range(0, 2047));
          13, 14: send_load(REQ_FONT, $urandom_range(0, FONT_DEPTH - 1), $urandom_range(0, 255));
          15, 16: send_load(REQ_CHAR, $urandom_range(0, LINE_DEPTH - 1), pick_code());
          17: send_load(REQ_CHAR, $urandom_range(LINE_DEPTH, FONT_DEPTH - 1),
                        $urandom_range(0, 255));
          18: send_load(REQ_UNKNOWN, $urandom_range(0, FONT_DEPTH - 1), $urandom_range(0, 255));
          default: send_pixel(band_panel_x(), $urandom_range(0, 2047));
        endcase
      end
    end

    drain();
    $display("run covered %0d request words, %0d pixel results checked, %0d register settings",
             words_sent, sb.checked, settings_run);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb_rotated_scaled_text_overlay: done, clean");
    end else begin
      $display("tb_rotated_scaled_text_overlay: done, errors");
    end
    $finish;
  end
endmodule

// ----- rotated_scaled_text_overlay.f -----
+incdir+hw/rtl
hw/rtl/rsto_pkg.sv
hw/rtl/rsto_if.sv
hw/rtl/rsto_ram.sv
hw/rtl/rotated_scaled_text_overlay.sv
bench/tb_rotated_scaled_text_overlay.sv
